>>> sv/ufx_pkg.sv
// Shared types and constants for the UART FIFO block with XON/XOFF flow control.
// Used by ufx_decide and uart_fifo_xon_xoff_flow; depends on nothing else.
package ufx_pkg;

	// Command codes carried in s_tuser
	localparam logic [1:0] CMD_LINE_RX  = 2'd0;
	localparam logic [1:0] CMD_HOST_WR  = 2'd1;
	localparam logic [1:0] CMD_HOST_RD  = 2'd2;
	localparam logic [1:0] CMD_TX_READY = 2'd3;

	// Software flow control characters
	localparam logic [7:0] XON_BYTE  = 8'h11;
	localparam logic [7:0] XOFF_BYTE = 8'h13;

	// Configuration register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_HIGH_THR = 2'd0;
	localparam logic [1:0] REG_LOW_THR  = 2'd1;
	localparam logic [1:0] REG_FLOW_EN  = 2'd2;

	// Register reset values
	localparam logic [4:0] HIGH_THR_RST = 5'd12;
	localparam logic [4:0] LOW_THR_RST  = 5'd4;
	localparam logic       FLOW_EN_RST  = 1'b1;

	// Default FIFO depths
	localparam int RX_DEPTH_DEF = 16;
	localparam int TX_DEPTH_DEF = 16;

	typedef struct packed {
		logic [4:0] high_thr;
		logic [4:0] low_thr;
		logic       flow_en;
	} cfg_t;

	// Decisions for one transaction, handed from ufx_decide to the datapath
	typedef struct packed {
		logic rx_store;       // append the line byte to the receive FIFO
		logic rx_pop;         // host read takes the receive head
		logic tx_append;      // host write appends to the transmit FIFO
		logic tx_pop;         // transmitter takes the transmit head
		logic push1;          // first control byte goes in front of the head
		logic push1_xoff;     // first control byte is XOFF, else XON
		logic push2;          // XON follows in front of that XOFF
		logic accepted;
		logic send_allowed_n;
		logic receive_open_n;
	} step_ctl_t;

endpackage

>>> sv/uart_fifo_xon_xoff_flow.sv
// Top level of the UART FIFO block: receive and transmit byte memories,
// pointers, XON/XOFF flags, APB registers and the result stages. Depends on
// ufx_pkg and ufx_decide.
//
//   channel   dir   handshake               payload
//   s_*       in    s_tvalid / s_tready     s_tuser = cmd, s_tdata = data_byte
//   m_*       out   m_tvalid / m_tready     m_tdata = result fields
//   apb       in    psel, penable, pwrite   paddr, pwdata, prdata (pready = 1)
//
// One item at a time: it is accepted only while the result stage is empty,
// the FIFO memories are read at the accepting edge, and their registered
// read data forms the result as the result stage loads the output register.
// A result then waits in the output register while the next item is taken.
// Reset clears pointers, counts, flags and registers; the byte memories are
// not cleared. A stalled m_tready holds the result stage and with it s_tready.
module uart_fifo_xon_xoff_flow import ufx_pkg::*; #(
	parameter int RX_DEPTH = RX_DEPTH_DEF,
	parameter int TX_DEPTH = TX_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] line_valid, [8:1] line_byte, [9] read_valid, [17:10] read_byte,
	// [18] accepted, [23:19] rx_fill, [28:24] tx_fill, [29] remote_paused,
	// [31:30] zero
	output logic [31:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int RP  = $clog2(RX_DEPTH);
	localparam int TP  = $clog2(TX_DEPTH);
	localparam int RC  = $clog2(RX_DEPTH + 1);
	localparam int TC  = $clog2(TX_DEPTH + 1);
	localparam int RSW = RC + 1;
	localparam int TSW = TC + 1;

	// Configuration registers
	cfg_t cfg_q;

	// FIFO state
	logic [7:0]    rx_mem [RX_DEPTH];
	logic [7:0]    tx_mem [TX_DEPTH];
	logic [RP-1:0] rx_head_q;
	logic [RC-1:0] rx_count_q;
	logic [TP-1:0] tx_head_q;
	logic [TC-1:0] tx_count_q;
	logic          send_allowed_q;
	logic          receive_open_q;
	logic [7:0]    rx_rd_q;
	logic [7:0]    tx_rd_q;

	// Result stage
	logic          valid_s1;
	logic          push2_s1;
	logic [TP-1:0] push2_addr_s1;
	logic          line_valid_s1;
	logic          read_valid_s1;
	logic          accepted_s1;
	logic [4:0]    rx_fill_s1;
	logic [4:0]    tx_fill_s1;
	logic          paused_s1;

	// Output register
	logic          out_valid_q;
	logic [31:0]   out_data_q;

	step_ctl_t     ctl;
	logic          s_fire;
	logic          s1_go;
	logic          cfg_wr;

	logic [RSW-1:0] rx_sum;
	logic [RP-1:0]  rx_tail;
	logic [RP-1:0]  rx_head_inc;
	logic [TSW-1:0] tx_sum;
	logic [TP-1:0]  tx_tail;
	logic [TP-1:0]  tx_head_inc;
	logic [TP-1:0]  tx_head_dec1;
	logic [TP-1:0]  tx_head_dec2;
	logic [RP-1:0]  rx_head_n;
	logic [RC-1:0]  rx_count_n;
	logic [TP-1:0]  tx_head_n;
	logic [TC-1:0]  tx_count_n;
	logic [RC+4:0]  rx_fill_ext;
	logic [TC+4:0]  tx_fill_ext;

	logic          tx_we;
	logic [TP-1:0] tx_waddr;
	logic [7:0]    tx_wdata;

	assign s_tready = !valid_s1;
	assign s_fire   = s_tvalid && s_tready;
	assign s1_go    = valid_s1 && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;

	ufx_decide #(
		.RX_DEPTH (RX_DEPTH),
		.TX_DEPTH (TX_DEPTH)
	) u_decide (
		.cmd          (s_tuser),
		.data_byte    (s_tdata),
		.rx_count     (rx_count_q),
		.tx_count     (tx_count_q),
		.send_allowed (send_allowed_q),
		.receive_open (receive_open_q),
		.cfg          (cfg_q),
		.ctl          (ctl)
	);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_thr <= HIGH_THR_RST;
			cfg_q.low_thr  <= LOW_THR_RST;
			cfg_q.flow_en  <= FLOW_EN_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_HIGH_THR: cfg_q.high_thr <= pwdata[4:0];
				REG_LOW_THR:  cfg_q.low_thr  <= pwdata[4:0];
				REG_FLOW_EN:  cfg_q.flow_en  <= pwdata[0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_HIGH_THR: prdata = {27'd0, cfg_q.high_thr};
			REG_LOW_THR:  prdata = {27'd0, cfg_q.low_thr};
			REG_FLOW_EN:  prdata = {31'd0, cfg_q.flow_en};
			default:      prdata = '0;
		endcase
	end

	// Wrap pointer arithmetic
	always_comb begin
		rx_sum = RSW'(rx_head_q) + RSW'(rx_count_q);
		if (rx_sum >= RSW'(RX_DEPTH)) begin
			rx_sum = rx_sum - RSW'(RX_DEPTH);
		end
		rx_tail     = rx_sum[RP-1:0];
		rx_head_inc = (rx_head_q == RP'(RX_DEPTH - 1)) ? '0 : rx_head_q + RP'(1);

		tx_sum = TSW'(tx_head_q) + TSW'(tx_count_q);
		if (tx_sum >= TSW'(TX_DEPTH)) begin
			tx_sum = tx_sum - TSW'(TX_DEPTH);
		end
		tx_tail      = tx_sum[TP-1:0];
		tx_head_inc  = (tx_head_q == TP'(TX_DEPTH - 1)) ? '0 : tx_head_q + TP'(1);
		tx_head_dec1 = (tx_head_q == '0) ? TP'(TX_DEPTH - 1) : tx_head_q - TP'(1);
		tx_head_dec2 = (tx_head_dec1 == '0) ? TP'(TX_DEPTH - 1) : tx_head_dec1 - TP'(1);
	end

	// Next pointers and counts
	always_comb begin
		rx_head_n  = rx_head_q;
		rx_count_n = rx_count_q;
		if (ctl.rx_store) begin
			rx_count_n = rx_count_q + RC'(1);
		end else if (ctl.rx_pop) begin
			rx_head_n  = rx_head_inc;
			rx_count_n = rx_count_q - RC'(1);
		end

		tx_head_n  = tx_head_q;
		tx_count_n = tx_count_q;
		if (ctl.push2) begin
			tx_head_n  = tx_head_dec2;
			tx_count_n = tx_count_q + TC'(2);
		end else if (ctl.push1) begin
			tx_head_n  = tx_head_dec1;
			tx_count_n = tx_count_q + TC'(1);
		end else if (ctl.tx_append) begin
			tx_count_n = tx_count_q + TC'(1);
		end else if (ctl.tx_pop) begin
			tx_head_n  = tx_head_inc;
			tx_count_n = tx_count_q - TC'(1);
		end
	end

	// Advance FIFO state on an accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q      <= '0;
			rx_count_q     <= '0;
			tx_head_q      <= '0;
			tx_count_q     <= '0;
			send_allowed_q <= 1'b1;
			receive_open_q <= 1'b1;
		end else if (s_fire) begin
			rx_head_q      <= rx_head_n;
			rx_count_q     <= rx_count_n;
			tx_head_q      <= tx_head_n;
			tx_count_q     <= tx_count_n;
			send_allowed_q <= ctl.send_allowed_n;
			receive_open_q <= ctl.receive_open_n;
		end
	end

	// Receive memory: store at the tail, read the head
	always_ff @(posedge clk) begin
		if (s_fire && ctl.rx_store) begin
			rx_mem[rx_tail] <= s_tdata;
		end
		if (s_fire) begin
			rx_rd_q <= rx_mem[rx_head_q];
		end
	end

	// Pick the transmit memory write: a trailing XON in the result cycle,
	// else a host append or a control byte in front of the head
	always_comb begin
		if (push2_s1) begin
			tx_we    = 1'b1;
			tx_waddr = push2_addr_s1;
			tx_wdata = XON_BYTE;
		end else begin
			tx_we    = s_fire && (ctl.tx_append || ctl.push1);
			tx_waddr = ctl.tx_append ? tx_tail : tx_head_dec1;
			tx_wdata = ctl.tx_append ? s_tdata : (ctl.push1_xoff ? XOFF_BYTE : XON_BYTE);
		end
	end

	// Transmit memory: one write port, head read at acceptance
	always_ff @(posedge clk) begin
		if (tx_we) begin
			tx_mem[tx_waddr] <= tx_wdata;
		end
		if (s_fire) begin
			tx_rd_q <= tx_mem[tx_head_q];
		end
	end

	assign rx_fill_ext = {5'd0, rx_count_n};
	assign tx_fill_ext = {5'd0, tx_count_n};

	// Result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			push2_s1 <= 1'b0;
		end else begin
			push2_s1 <= s_fire && ctl.push2;
			if (s_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		if (s_fire) begin
			push2_addr_s1 <= tx_head_dec2;
			line_valid_s1 <= ctl.tx_pop;
			read_valid_s1 <= ctl.rx_pop;
			accepted_s1   <= ctl.accepted;
			rx_fill_s1    <= rx_fill_ext[4:0];
			tx_fill_s1    <= tx_fill_ext[4:0];
			paused_s1     <= !ctl.send_allowed_n;
		end
	end

	// Output register: load from the result stage, drop on transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_data_q <= {2'd0, paused_s1, tx_fill_s1, rx_fill_s1, accepted_s1,
				(read_valid_s1 ? rx_rd_q : 8'd0), read_valid_s1,
				(line_valid_s1 ? tx_rd_q : 8'd0), line_valid_s1};
		end
	end

endmodule

>>> sv/ufx_decide.sv
// Command decode and XON/XOFF threshold decisions for one transaction.
// Depends on ufx_pkg (command codes, cfg_t, step_ctl_t).
module ufx_decide import ufx_pkg::*; #(
	parameter int RX_DEPTH = RX_DEPTH_DEF,
	parameter int TX_DEPTH = TX_DEPTH_DEF,
	localparam int RC = $clog2(RX_DEPTH + 1),
	localparam int TC = $clog2(TX_DEPTH + 1)
) (
	input  logic [1:0]    cmd,
	input  logic [7:0]    data_byte,
	input  logic [RC-1:0] rx_count,
	input  logic [TC-1:0] tx_count,
	input  logic          send_allowed,
	input  logic          receive_open,
	input  cfg_t          cfg,
	output step_ctl_t     ctl
);

	localparam int CW = (RC > 5) ? RC : 5;

	logic          rx_full;
	logic          tx_full;
	logic          tx_one_left;
	logic          check;
	logic [RC-1:0] rx_next;
	logic          go_high;
	logic          go_low;
	logic          open_mid;

	assign rx_full     = (rx_count == RC'(RX_DEPTH));
	assign tx_full     = (tx_count == TC'(TX_DEPTH));
	assign tx_one_left = (tx_count == TC'(TX_DEPTH - 1));

	// Decode the command
	always_comb begin
		ctl                = '0;
		ctl.accepted       = 1'b1;
		ctl.send_allowed_n = send_allowed;
		check              = 1'b0;
		rx_next            = rx_count;
		unique case (cmd)
			CMD_LINE_RX: begin
				if (cfg.flow_en && data_byte == XON_BYTE) begin
					ctl.send_allowed_n = 1'b1;
				end else if (cfg.flow_en && data_byte == XOFF_BYTE) begin
					ctl.send_allowed_n = 1'b0;
				end else if (!rx_full) begin
					ctl.rx_store = 1'b1;
					check        = 1'b1;
					rx_next      = rx_count + RC'(1);
				end
			end
			CMD_HOST_WR: begin
				if ((cfg.flow_en && !send_allowed) || tx_full) begin
					ctl.accepted = 1'b0;
				end else begin
					ctl.tx_append = 1'b1;
				end
			end
			CMD_HOST_RD: begin
				if (rx_count == '0) begin
					ctl.accepted = 1'b0;
				end else begin
					ctl.rx_pop = 1'b1;
					check      = 1'b1;
					rx_next    = rx_count - RC'(1);
				end
			end
			CMD_TX_READY: begin
				if (tx_count != '0 && (send_allowed || !cfg.flow_en)) begin
					ctl.tx_pop = 1'b1;
				end
			end
			default: begin
				ctl.accepted = 1'b1;
			end
		endcase

		// Check thresholds: XOFF first, then XON
		go_high  = check && cfg.flow_en && receive_open &&
			(CW'(rx_next) > CW'(cfg.high_thr));
		open_mid = receive_open && !go_high;
		go_low   = check && cfg.flow_en && !open_mid &&
			(CW'(rx_next) < CW'(cfg.low_thr));

		ctl.receive_open_n = go_low ? 1'b1 : open_mid;
		ctl.push1          = (go_high || go_low) && !tx_full;
		ctl.push1_xoff     = go_high;
		ctl.push2          = go_high && go_low && !tx_full && !tx_one_left;
	end

endmodule

>>> tb/uart_fifo_xon_xoff_flow_tb.sv
// Self-checking testbench for uart_fifo_xon_xoff_flow: drives random command streams
// through the FIFOs under several flow-control settings and stall patterns, and
// predicts every result. Depends on ufx_pkg and the RTL of the block only.
module uart_fifo_xon_xoff_flow_tb;
	import ufx_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 400;
	localparam int PHASES         = 8;
	localparam int RANDOM_ITEMS   = 205;

	// Result fields, lowest bit last
	typedef struct packed {
		logic [1:0] pad;
		logic       paused;
		logic [4:0] tx_fill;
		logic [4:0] rx_fill;
		logic       accepted;
		logic [7:0] read_byte;
		logic       read_valid;
		logic [7:0] line_byte;
		logic       line_valid;
	} ufx_out_t;

	typedef struct {
		logic [1:0] cmd;
		logic [7:0] data;
	} bus_cmd_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;   // [7:0] data_byte
	logic [1:0]  s_tuser  = '0;   // [1:0] cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [0] line_valid, [8:1] line_byte, [9] read_valid, [17:10] read_byte,
	// [18] accepted, [23:19] rx_fill, [28:24] tx_fill, [29] remote_paused
	logic [31:0] m_tdata;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	uart_fifo_xon_xoff_flow u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Predicted FIFO contents, pointers and flags
	logic [7:0] rx_mem [RX_DEPTH_DEF];
	logic [3:0] rx_rd   = '0;
	logic [4:0] rx_cnt  = '0;
	logic [7:0] tx_mem [TX_DEPTH_DEF];
	logic [3:0] tx_rd   = '0;
	logic [4:0] tx_cnt  = '0;
	logic       peer_go = 1'b1;
	logic       rx_open = 1'b1;
	logic [4:0] hi_thr  = HIGH_THR_RST;
	logic [4:0] lo_thr  = LOW_THR_RST;
	logic       flow_on = FLOW_EN_RST;

	bus_cmd_t    pending_cmds[$];
	ufx_out_t    due_results[$];
	int unsigned mismatches = 0;
	int          gap_pct    = 0;
	int          stall_pct  = 0;
	logic        s_taken    = 1'b0;
	logic        hold_kick  = 1'b0;
	logic        hold_seen  = 1'b0;
	int          hold_left  = 0;
	int          quiet      = 0;

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
	endtask

	// Put a control byte in front of the transmit head, drop it when full
	function automatic void tx_front(logic [7:0] b);
		if (tx_cnt < 5'(TX_DEPTH_DEF)) begin
			tx_rd = tx_rd - 4'd1;
			tx_mem[tx_rd] = b;
			tx_cnt++;
		end
	endfunction

	// Send XOFF when the receive fill rises above the high mark, XON below the low mark
	function automatic void watch_fill();
		if (flow_on) begin
			if (rx_cnt > hi_thr && rx_open) begin
				rx_open = 1'b0;
				tx_front(XOFF_BYTE);
			end
			if (rx_cnt < lo_thr && !rx_open) begin
				rx_open = 1'b1;
				tx_front(XON_BYTE);
			end
		end
	endfunction

	// Advance the predicted state by one command and return the result it causes
	function automatic ufx_out_t fifo_step(logic [1:0] cmd, logic [7:0] b);
		ufx_out_t r;
		r = '0;
		r.accepted = 1'b1;
		case (cmd)
			CMD_LINE_RX: begin
				if (flow_on && b == XON_BYTE)
					peer_go = 1'b1;
				else if (flow_on && b == XOFF_BYTE)
					peer_go = 1'b0;
				else if (rx_cnt < 5'(RX_DEPTH_DEF)) begin
					rx_mem[4'(rx_rd + rx_cnt[3:0])] = b;
					rx_cnt++;
					watch_fill();
				end
			end
			CMD_HOST_WR: begin
				if ((flow_on && !peer_go) || tx_cnt >= 5'(TX_DEPTH_DEF))
					r.accepted = 1'b0;
				else begin
					tx_mem[4'(tx_rd + tx_cnt[3:0])] = b;
					tx_cnt++;
				end
			end
			CMD_HOST_RD: begin
				if (rx_cnt == 0)
					r.accepted = 1'b0;
				else begin
					r.read_byte  = rx_mem[rx_rd];
					r.read_valid = 1'b1;
					rx_rd = rx_rd + 4'd1;
					rx_cnt--;
					watch_fill();
				end
			end
			CMD_TX_READY: begin
				if (tx_cnt > 0 && (peer_go || !flow_on)) begin
					r.line_byte  = tx_mem[tx_rd];
					r.line_valid = 1'b1;
					tx_rd = tx_rd + 4'd1;
					tx_cnt--;
				end
			end
			default: ;
		endcase
		r.rx_fill = rx_cnt;
		r.tx_fill = tx_cnt;
		r.paused  = !peer_go;
		return r;
	endfunction

	// Drive the next command once the current one is taken, with random gaps
	always @(negedge clk) begin
		if (!s_tvalid || s_taken) begin
			if (pending_cmds.size() > 0 && $urandom_range(99) >= gap_pct) begin
				s_tuser  <= pending_cmds[0].cmd;
				s_tdata  <= pending_cmds[0].data;
				s_tvalid <= 1'b1;
				void'(pending_cmds.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Drive m_tready: a long hold on request, else random stalls
	always @(negedge clk) begin
		if (hold_kick != hold_seen) begin
			hold_seen <= hold_kick;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Check each result against the oldest prediction, predict each accepted command
	always @(posedge clk) begin
		ufx_out_t got, want;
		s_taken <= s_tvalid && s_tready;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (due_results.size() == 0) begin
				report_mismatch("result with none expected", m_tdata, 32'd0);
			end else begin
				want = due_results.pop_front();
				if (got.line_valid !== want.line_valid)
					report_mismatch("line_valid", got.line_valid, want.line_valid);
				if (got.line_byte !== want.line_byte)
					report_mismatch("line_byte", got.line_byte, want.line_byte);
				if (got.read_valid !== want.read_valid)
					report_mismatch("read_valid", got.read_valid, want.read_valid);
				if (got.read_byte !== want.read_byte)
					report_mismatch("read_byte", got.read_byte, want.read_byte);
				if (got.accepted !== want.accepted)
					report_mismatch("accepted", got.accepted, want.accepted);
				if (got.rx_fill !== want.rx_fill)
					report_mismatch("rx_fill", got.rx_fill, want.rx_fill);
				if (got.tx_fill !== want.tx_fill)
					report_mismatch("tx_fill", got.tx_fill, want.tx_fill);
				if (got.paused !== want.paused)
					report_mismatch("remote_paused", got.paused, want.paused);
				if (got.pad !== want.pad)
					report_mismatch("unused bits", got.pad, want.pad);
			end
		end
		if (s_tvalid && s_tready)
			due_results.push_back(fifo_step(s_tuser, s_tdata));
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic read_reg(logic [1:0] idx, logic [4:0] want);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== 32'(want))
			report_mismatch("register readback", prdata, 32'(want));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write a register with junk in the unused bits, then read it back
	task automatic set_reg(logic [1:0] idx, logic [4:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= ($urandom() & 32'hFFFF_FFE0) | 32'(val);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_HIGH_THR: hi_thr = val;
			REG_LOW_THR:  lo_thr = val;
			REG_FLOW_EN:  flow_on = val[0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		read_reg(idx, val);
	endtask

	task automatic push_cmd(logic [1:0] cmd, logic [7:0] data);
		bus_cmd_t c;
		c.cmd  = cmd;
		c.data = data;
		pending_cmds.push_back(c);
	endtask

	// Random traffic in bursts: fill receive, drain receive, fill transmit, or mixed
	task automatic queue_traffic(int n);
		int mode, left, pick, dpick;
		logic [1:0] cmd;
		logic [7:0] data;
		mode = 0;
		left = 0;
		repeat (n) begin
			if (left == 0) begin
				mode = $urandom_range(3);
				left = $urandom_range(8, 40);
			end
			left--;
			pick = $urandom_range(99);
			case (mode)
				0: cmd = pick < 80 ? CMD_LINE_RX : pick < 88 ? CMD_HOST_RD :
					pick < 94 ? CMD_TX_READY : CMD_HOST_WR;
				1: cmd = pick < 75 ? CMD_HOST_RD : pick < 85 ? CMD_LINE_RX :
					pick < 95 ? CMD_TX_READY : CMD_HOST_WR;
				2: cmd = pick < 65 ? CMD_HOST_WR : pick < 80 ? CMD_TX_READY :
					pick < 92 ? CMD_LINE_RX : CMD_HOST_RD;
				default: cmd = 2'($urandom_range(3));
			endcase
			dpick = $urandom_range(99);
			data  = 8'($urandom_range(255));
			if (cmd == CMD_LINE_RX && dpick < 8)
				data = XON_BYTE;
			else if (cmd == CMD_LINE_RX && dpick < 16)
				data = XOFF_BYTE;
			else if (cmd == CMD_HOST_WR && dpick < 5)
				data = XON_BYTE;
			else if (cmd == CMD_HOST_WR && dpick < 10)
				data = XOFF_BYTE;
			push_cmd(cmd, data);
		end
	endtask

	// Wait until every command is taken and every result checked, then let the block settle
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || (s_tvalid && !s_taken) || due_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Per-phase settings: thresholds, flow enable, sender gap and receiver stall
	int ph_hi    [PHASES] = '{2, 0, 16, 8, 12, 15, 5, 16};
	int ph_lo    [PHASES] = '{1, 16, 0, 3, 4, 15, 10, 16};
	int ph_fe    [PHASES] = '{1, 1, 1, 0, 1, 1, 1, 0};
	int ph_gap   [PHASES] = '{0, 46, 0, 31, 0, 31, 46, 0};
	int ph_stall [PHASES] = '{0, 0, 46, 31, 0, 31, 0, 46};

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Registers come up at their reset values
		read_reg(REG_HIGH_THR, HIGH_THR_RST);
		read_reg(REG_LOW_THR, LOW_THR_RST);
		read_reg(REG_FLOW_EN, 5'(FLOW_EN_RST));

		for (int p = 0; p < PHASES; p++) begin
			set_reg(REG_HIGH_THR, 5'(ph_hi[p]));
			set_reg(REG_LOW_THR, 5'(ph_lo[p]));
			set_reg(REG_FLOW_EN, 5'(ph_fe[p]));
			gap_pct   = ph_gap[p];
			stall_pct = ph_stall[p];
			if (p == 0) begin
				// Empty FIFOs, pause and resume, threshold crossing and drain
				push_cmd(CMD_TX_READY, 8'h00);
				push_cmd(CMD_HOST_RD, 8'hFF);
				push_cmd(CMD_HOST_WR, 8'h00);
				push_cmd(CMD_HOST_WR, 8'hFF);
				push_cmd(CMD_TX_READY, 8'hFF);
				push_cmd(CMD_LINE_RX, XOFF_BYTE);
				push_cmd(CMD_HOST_WR, 8'h5A);
				push_cmd(CMD_TX_READY, 8'h00);
				push_cmd(CMD_LINE_RX, XON_BYTE);
				push_cmd(CMD_TX_READY, 8'h00);
				push_cmd(CMD_LINE_RX, 8'h00);
				push_cmd(CMD_LINE_RX, 8'hFF);
				push_cmd(CMD_LINE_RX, 8'h80);
				push_cmd(CMD_LINE_RX, 8'h01);
				push_cmd(CMD_HOST_RD, 8'h00);
				push_cmd(CMD_HOST_RD, 8'h00);
				push_cmd(CMD_HOST_RD, 8'h00);
				push_cmd(CMD_HOST_RD, 8'h00);
				push_cmd(CMD_TX_READY, 8'h00);
				push_cmd(CMD_TX_READY, 8'h00);
				push_cmd(CMD_TX_READY, 8'h00);
			end
			queue_traffic(RANDOM_ITEMS);
			// Hold the output side off while the sender keeps offering
			if (p == 4)
				hold_kick = ~hold_kick;
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (due_results.size() != 0)
			report_mismatch("results never produced", due_results.size(), 32'd0);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/ufx_pkg.sv
sv/ufx_decide.sv
sv/uart_fifo_xon_xoff_flow.sv
tb/uart_fifo_xon_xoff_flow_tb.sv
